// ===== rtl/core/bandpass_adaptive_envelope_follower_defines.svh =====
// Assertion macros for the bandpass envelope follower.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef BANDPASS_ADAPTIVE_ENVELOPE_FOLLOWER_DEFINES_SVH
`define BANDPASS_ADAPTIVE_ENVELOPE_FOLLOWER_DEFINES_SVH

// same-cycle implication
`define BAEF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication
`define BAEF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== rtl/core/baef_pkg.sv =====
// Shared types, constants and helpers for the bandpass envelope follower.
// No dependencies.
package baef_pkg;

  localparam int FRAME_LEN = 32;
  localparam int IDX_W     = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;
  localparam int FRAME_SH  = $clog2(FRAME_LEN);
  localparam int SUM_W     = 22;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 18;

  localparam logic [16:0] Q16_ONE = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] REG_BAND_GAIN   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FB_FIRST    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_FB_SECOND   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK      = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_DECAY       = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_SLOW        = CFG_IDX_W'(5);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_F0, ST_F1, ST_F2, ST_F3, ST_F4,
    ST_T0, ST_T1, ST_T2, ST_T3,
    ST_R0, ST_R1,
    ST_E0, ST_E1, ST_E2, ST_E3, ST_E4
  } state_t;

  typedef enum logic [2:0] {
    MUL_FB0, MUL_FA1, MUL_FA2, MUL_TM, MUL_TS, MUL_EN, MUL_EL, MUL_EH
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB, ACC_ADD_RND
  } acc_op_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     cap_sample;
    logic     filt_done;
    logic     thr_done;
    logic     rd_en;
    logic     pole_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic frame_last;
    logic rep_last;
  } sts_t;

  function automatic logic [16:0] pole_clamp(input logic [16:0] c);
    return (c > Q16_ONE) ? Q16_ONE : c;
  endfunction

  function automatic logic [16:0] one_minus(input logic [16:0] c);
    return Q16_ONE - c;
  endfunction

endpackage

// ===== rtl/core/baef_dp.sv =====
// Datapath: coefficient registers, shared 18x18 multiplier, accumulator,
// filter state, frame store and output payload. Uses baef_pkg.
module baef_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [baef_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [baef_pkg::CFG_DAT_W-1:0] cfg_wdata,
  input  logic signed [15:0]             in_sample,
  input  baef_pkg::cmd_t                 cmd,
  output baef_pkg::sts_t                 sts,
  output logic [14:0]                    out_envelope,
  output logic                           out_frame_end
);

  logic [16:0]        b0_r, att_r, dec_r, slow_r;
  logic signed [17:0] a1_r, a2_r;

  logic signed [15:0] x_r, xd1_r, xd2_r, yd1_r, yd2_r;
  logic signed [15:0] xd1_nxt, xd2_nxt, yd1_nxt, yd2_nxt;
  logic [baef_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [15:0]        thr_r, thr_nxt;
  logic [31:0]        env_r, env_nxt;
  logic [baef_pkg::IDX_W-1:0] cnt_r, cnt_nxt, rd_idx_r, rd_idx_nxt;

  logic signed [35:0] prod_r;
  logic signed [36:0] acc_r, acc_nxt;
  logic signed [17:0] mul_a, mul_b;
  logic signed [36:0] prod_ext, rnd_sum, rnd_val;

  logic signed [15:0] mem [baef_pkg::FRAME_LEN];
  logic signed [15:0] rd_data_r;
  logic [16:0]        r_r, c_r;

  logic [14:0]        env_out_r;
  logic               frame_end_r;

  logic [16:0]        att_c, dec_c, slow_c;
  logic signed [16:0] xdiff;
  logic [16:0]        mean;
  logic signed [36:0] fsum, yfull;
  logic signed [15:0] y;
  logic [16:0]        y_mag, rd_mag;
  logic [36:0]        tsum;
  logic [32:0]        lsum;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r   <= '0;
      a1_r   <= '0;
      a2_r   <= '0;
      att_r  <= '0;
      dec_r  <= '0;
      slow_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        baef_pkg::REG_BAND_GAIN: b0_r   <= cfg_wdata[16:0];
        baef_pkg::REG_FB_FIRST:  a1_r   <= $signed(cfg_wdata);
        baef_pkg::REG_FB_SECOND: a2_r   <= $signed(cfg_wdata);
        baef_pkg::REG_ATTACK:    att_r  <= cfg_wdata[16:0];
        baef_pkg::REG_DECAY:     dec_r  <= cfg_wdata[16:0];
        baef_pkg::REG_SLOW:      slow_r <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  assign att_c  = baef_pkg::pole_clamp(att_r);
  assign dec_c  = baef_pkg::pole_clamp(dec_r);
  assign slow_c = baef_pkg::pole_clamp(slow_r);

  assign xdiff = {x_r[15], x_r} - {xd2_r[15], xd2_r};
  assign mean  = 17'(sum_r >> baef_pkg::FRAME_SH);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      baef_pkg::MUL_FB0: begin
        mul_a = $signed({1'b0, b0_r});
        mul_b = {xdiff[16], xdiff};
      end
      baef_pkg::MUL_FA1: begin
        mul_a = a1_r;
        mul_b = 18'(yd1_r);
      end
      baef_pkg::MUL_FA2: begin
        mul_a = a2_r;
        mul_b = 18'(yd2_r);
      end
      baef_pkg::MUL_TM: begin
        mul_a = $signed({1'b0, baef_pkg::one_minus(slow_c)});
        mul_b = $signed({1'b0, mean});
      end
      baef_pkg::MUL_TS: begin
        mul_a = $signed({1'b0, slow_c});
        mul_b = $signed({2'b00, thr_r});
      end
      baef_pkg::MUL_EN: begin
        mul_a = $signed({1'b0, baef_pkg::one_minus(c_r)});
        mul_b = $signed({1'b0, r_r});
      end
      baef_pkg::MUL_EL: begin
        mul_a = $signed({1'b0, c_r});
        mul_b = $signed({2'b00, env_r[15:0]});
      end
      baef_pkg::MUL_EH: begin
        mul_a = $signed({1'b0, c_r});
        mul_b = $signed({2'b00, env_r[31:16]});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // accumulator
  assign prod_ext = {prod_r[35], prod_r};
  assign rnd_sum  = prod_ext + 37'sd32768;
  assign rnd_val  = rnd_sum >>> 16;

  always_comb begin
    acc_nxt = acc_r;
    case (cmd.acc_op)
      baef_pkg::ACC_LOAD:    acc_nxt = prod_ext;
      baef_pkg::ACC_ADD:     acc_nxt = acc_r + prod_ext;
      baef_pkg::ACC_SUB:     acc_nxt = acc_r - prod_ext;
      baef_pkg::ACC_ADD_RND: acc_nxt = acc_r + rnd_val;
      default:               acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // filter output: round half up, saturate
  assign fsum  = acc_r + 37'sd32768;
  assign yfull = fsum >>> 16;

  always_comb begin
    if (yfull > 37'sd32767) begin
      y = 16'sh7FFF;
    end else if (yfull < -37'sd32768) begin
      y = 16'sh8000;
    end else begin
      y = yfull[15:0];
    end
  end

  assign y_mag  = y[15] ? 17'(-{y[15], y}) : {1'b0, y};
  assign rd_mag = rd_data_r[15] ? 17'(-{rd_data_r[15], rd_data_r}) : {1'b0, rd_data_r};

  assign tsum = acc_r + 37'sd32768;
  assign lsum = {1'b0, acc_r[31:0]} + 33'd32768;

  assign sts.frame_last = (cnt_r == baef_pkg::IDX_W'(baef_pkg::FRAME_LEN - 1));
  assign sts.rep_last   = (rd_idx_r == baef_pkg::IDX_W'(baef_pkg::FRAME_LEN - 1));

  always_ff @(posedge clk) begin
    if (cmd.cap_sample) begin
      x_r <= in_sample;
    end
  end

  // state next values
  always_comb begin
    xd1_nxt    = xd1_r;
    xd2_nxt    = xd2_r;
    yd1_nxt    = yd1_r;
    yd2_nxt    = yd2_r;
    sum_nxt    = sum_r;
    cnt_nxt    = cnt_r;
    thr_nxt    = thr_r;
    env_nxt    = env_r;
    rd_idx_nxt = rd_idx_r;
    if (cmd.filt_done) begin
      xd2_nxt = xd1_r;
      xd1_nxt = x_r;
      yd2_nxt = yd1_r;
      yd1_nxt = y;
      sum_nxt = sum_r + baef_pkg::SUM_W'(y_mag);
      cnt_nxt = sts.frame_last ? '0 : cnt_r + 1'b1;
    end
    if (cmd.thr_done) begin
      thr_nxt    = tsum[31:16];
      sum_nxt    = '0;
      rd_idx_nxt = '0;
    end
    if (cmd.out_load) begin
      env_nxt    = acc_r[31:0];
      rd_idx_nxt = sts.rep_last ? '0 : rd_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xd1_r    <= '0;
      xd2_r    <= '0;
      yd1_r    <= '0;
      yd2_r    <= '0;
      sum_r    <= '0;
      cnt_r    <= '0;
      thr_r    <= '0;
      env_r    <= '0;
      rd_idx_r <= '0;
    end else begin
      xd1_r    <= xd1_nxt;
      xd2_r    <= xd2_nxt;
      yd1_r    <= yd1_nxt;
      yd2_r    <= yd2_nxt;
      sum_r    <= sum_nxt;
      cnt_r    <= cnt_nxt;
      thr_r    <= thr_nxt;
      env_r    <= env_nxt;
      rd_idx_r <= rd_idx_nxt;
    end
  end

  // frame store
  always_ff @(posedge clk) begin
    if (cmd.filt_done) begin
      mem[cnt_r] <= y;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_idx_r];
    end
  end

  // magnitude and pole for the replayed entry
  always_ff @(posedge clk) begin
    if (cmd.pole_sel) begin
      r_r <= rd_mag;
      c_r <= (rd_mag > {1'b0, thr_r}) ? att_c : dec_c;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      env_out_r   <= (lsum[32:16] > 17'd32767) ? 15'h7FFF : lsum[30:16];
      frame_end_r <= sts.rep_last;
    end
  end

  assign out_envelope  = env_out_r;
  assign out_frame_end = frame_end_r;

endmodule

// ===== rtl/core/baef_ctrl.sv =====
// Controller: sequences filter, threshold and frame replay on the datapath,
// owns the input stall and output valid. Uses baef_pkg and the assertion macros.
`include "bandpass_adaptive_envelope_follower_defines.svh"

module baef_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  baef_pkg::sts_t sts,
  output baef_pkg::cmd_t cmd
);

  baef_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != baef_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= baef_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.mul_sel    = baef_pkg::MUL_FB0;
    cmd.acc_op     = baef_pkg::ACC_HOLD;
    case (state_r)
      baef_pkg::ST_IDLE: begin
        cmd.cap_sample = in_valid;
        if (in_valid) begin
          state_nxt = baef_pkg::ST_F0;
        end
      end
      baef_pkg::ST_F0: begin
        cmd.mul_sel = baef_pkg::MUL_FB0;
        state_nxt   = baef_pkg::ST_F1;
      end
      baef_pkg::ST_F1: begin
        cmd.mul_sel = baef_pkg::MUL_FA1;
        cmd.acc_op  = baef_pkg::ACC_LOAD;
        state_nxt   = baef_pkg::ST_F2;
      end
      baef_pkg::ST_F2: begin
        cmd.mul_sel = baef_pkg::MUL_FA2;
        cmd.acc_op  = baef_pkg::ACC_SUB;
        state_nxt   = baef_pkg::ST_F3;
      end
      baef_pkg::ST_F3: begin
        cmd.acc_op = baef_pkg::ACC_SUB;
        state_nxt  = baef_pkg::ST_F4;
      end
      baef_pkg::ST_F4: begin
        cmd.filt_done = 1'b1;
        state_nxt     = sts.frame_last ? baef_pkg::ST_T0 : baef_pkg::ST_IDLE;
      end
      baef_pkg::ST_T0: begin
        cmd.mul_sel = baef_pkg::MUL_TM;
        state_nxt   = baef_pkg::ST_T1;
      end
      baef_pkg::ST_T1: begin
        cmd.mul_sel = baef_pkg::MUL_TS;
        cmd.acc_op  = baef_pkg::ACC_LOAD;
        state_nxt   = baef_pkg::ST_T2;
      end
      baef_pkg::ST_T2: begin
        cmd.acc_op = baef_pkg::ACC_ADD;
        state_nxt  = baef_pkg::ST_T3;
      end
      baef_pkg::ST_T3: begin
        cmd.thr_done = 1'b1;
        state_nxt    = baef_pkg::ST_R0;
      end
      baef_pkg::ST_R0: begin
        cmd.rd_en = 1'b1;
        state_nxt = baef_pkg::ST_R1;
      end
      baef_pkg::ST_R1: begin
        cmd.pole_sel = 1'b1;
        state_nxt    = baef_pkg::ST_E0;
      end
      baef_pkg::ST_E0: begin
        cmd.mul_sel = baef_pkg::MUL_EN;
        state_nxt   = baef_pkg::ST_E1;
      end
      baef_pkg::ST_E1: begin
        cmd.mul_sel = baef_pkg::MUL_EL;
        cmd.acc_op  = baef_pkg::ACC_LOAD;
        state_nxt   = baef_pkg::ST_E2;
      end
      baef_pkg::ST_E2: begin
        cmd.mul_sel = baef_pkg::MUL_EH;
        cmd.acc_op  = baef_pkg::ACC_ADD_RND;
        state_nxt   = baef_pkg::ST_E3;
      end
      baef_pkg::ST_E3: begin
        cmd.acc_op = baef_pkg::ACC_ADD;
        state_nxt  = baef_pkg::ST_E4;
      end
      baef_pkg::ST_E4: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = sts.rep_last ? baef_pkg::ST_IDLE : baef_pkg::ST_R0;
        end
      end
      default: state_nxt = baef_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  `BAEF_ASSERT_NEXT(a_accept_starts_filter, (in_valid && !in_stall), (state_r == baef_pkg::ST_F0))
  `BAEF_ASSERT_IMPL(a_valid_from_replay, $rose(out_valid_r), ($past(state_r) == baef_pkg::ST_E4))
  `BAEF_ASSERT_NEXT(a_replay_waits, (state_r == baef_pkg::ST_E4 && out_valid_r && out_stall), (state_r == baef_pkg::ST_E4))
  `BAEF_ASSERT_IMPL(a_thr_after_frame, (state_r == baef_pkg::ST_T0), ($past(state_r) == baef_pkg::ST_F4))

endmodule

// ===== rtl/core/bandpass_adaptive_envelope_follower.sv =====
// Bandpass envelope follower top: controller plus datapath on one 18x18 multiplier.
// A sample that does not close a frame runs states F0 to F4; in_stall holds off the next one until idle.
// The frame-closing sample then runs threshold states T0 to T3 and replays the frame
// through R0, R1 and E0 to E4, one result per entry (32 per frame); output stall holds E4.
// Synchronous active-low reset clears config, filter state, sums, threshold and envelope;
// the frame store is not cleared and needs no clearing pass.
module bandpass_adaptive_envelope_follower (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [baef_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [baef_pkg::CFG_DAT_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [15:0]             in_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [14:0]                    out_envelope,
  output logic                           out_frame_end
);

  baef_pkg::cmd_t cmd;
  baef_pkg::sts_t sts;

  baef_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  baef_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_sample     (in_sample),
    .cmd           (cmd),
    .sts           (sts),
    .out_envelope  (out_envelope),
    .out_frame_end (out_frame_end)
  );

endmodule
